>>> sv/utf8_pkg.sv
// Package: constants and types for the UTF-8 stream decoder.
package utf8_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [CpWidth-1:0] REPL_CHAR    = 21'h00FFFD;
    localparam logic [CpWidth-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CpWidth-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CpWidth-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CpWidth-1:0] MIN_CP_2BYTE = 21'h000080;
    localparam logic [CpWidth-1:0] MIN_CP_3BYTE = 21'h000800;
    localparam logic [CpWidth-1:0] MIN_CP_4BYTE = 21'h010000;

    // Byte class masks and match patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Results owed for one accepted byte: err_count replacements, then an
    // optional good code point.
    typedef struct packed {
        logic [2:0]         err_count;
        logic               good;
        logic [CpWidth-1:0] cp;
        logic               text_end;
    } result_desc_t;

endpackage

>>> sv/utf8_stream_decoder_core.sv
// Top level: UTF-8 byte stream decoder with validation and error replacement.
//
//   channel | signals                                        | role
//   --------+------------------------------------------------+-------------------------
//   in      | in_valid, in_ready, data_byte, text_end        | one raw byte per item
//   out     | out_valid, out_ready, code_point, bad_sequence,| one code point per item
//           | run_last, final_result                         |
//
// Each byte is decoded in the cycle it is accepted; the sequence state advances
// at once and the results it owes go into a descriptor register.
// A byte that yields n results (error flush, up to 4) holds the descriptor,
// and so keeps in_ready low, until the last of them has been emitted.
// Results leave through a registered output stage, so a byte is taken while
// an earlier result still waits for out_ready.
// rst_n clears the pending sequence, the descriptor and the output stage.
module utf8_stream_decoder_core
    import utf8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               text_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CpWidth-1:0] code_point,
    output logic               bad_sequence,
    output logic               run_last,
    output logic               final_result
);

    // Pending multi-byte sequence
    logic [1:0]         held_reg, held_next;
    logic [1:0]         need_reg, need_next;
    logic [CpWidth-1:0] val_reg, val_next;

    // Results owed by the last accepted byte
    logic               desc_valid_reg, desc_valid_next;
    result_desc_t       desc_reg, desc_next;
    result_desc_t       new_desc;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    logic [CpWidth-1:0] cp_reg, cp_next;
    logic               bad_reg, bad_next;
    logic               run_last_reg, run_last_next;
    logic               final_reg, final_next;

    logic               in_fire;
    logic               out_free;
    logic               emit;
    logic               emit_last;
    logic               desc_done;

    // Decode helpers
    logic               is_cont;
    logic               extend;
    logic [CpWidth-1:0] ext_val;
    logic [2:0]         total;
    logic [CpWidth-1:0] min_cp;
    logic               value_ok;

    // ------------------------------------------------------------------
    // Decode one byte against the pending sequence
    // ------------------------------------------------------------------
    assign is_cont = (data_byte & CONT_MASK) == CONT_PAT;
    assign extend  = (held_reg != 2'd0) && (need_reg != 2'd0) && is_cont;
    assign ext_val = {val_reg[CpWidth-7:0], data_byte[5:0]};
    assign total   = {1'b0, held_reg} + 3'd1;

    always_comb
    begin
        case (total)
            3'd2:    min_cp = MIN_CP_2BYTE;
            3'd3:    min_cp = MIN_CP_3BYTE;
            default: min_cp = MIN_CP_4BYTE;
        endcase
    end

    assign value_ok = (ext_val >= min_cp)
                   && !((ext_val >= SURR_LO) && (ext_val <= SURR_HI))
                   && (ext_val <= CP_MAX);

    always_comb
    begin
        held_next          = held_reg;
        need_next          = need_reg;
        val_next           = val_reg;
        new_desc.err_count = 3'd0;
        new_desc.good      = 1'b0;
        new_desc.cp        = {{(CpWidth-8){1'b0}}, data_byte};
        new_desc.text_end  = text_end;

        if (extend)
        begin
            if (need_reg == 2'd1)
            begin
                // Sequence complete: emit the value or one replacement per byte
                if (value_ok)
                begin
                    new_desc.good = 1'b1;
                    new_desc.cp   = ext_val;
                end
                else
                begin
                    new_desc.err_count = total;
                end
                held_next = 2'd0;
                need_next = 2'd0;
                val_next  = '0;
            end
            else
            begin
                held_next = total[1:0];
                need_next = need_reg - 2'd1;
                val_next  = ext_val;
            end
        end
        else
        begin
            // Drop any interrupted sequence, then start afresh with this byte
            new_desc.err_count = {1'b0, held_reg};
            held_next          = 2'd0;
            need_next          = 2'd0;
            val_next           = '0;
            if (!data_byte[7])
            begin
                new_desc.good = 1'b1;
            end
            else if ((data_byte & LEAD2_MASK) == LEAD2_PAT)
            begin
                held_next = 2'd1;
                need_next = 2'd1;
                val_next  = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
            end
            else if ((data_byte & LEAD3_MASK) == LEAD3_PAT)
            begin
                held_next = 2'd1;
                need_next = 2'd2;
                val_next  = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
            end
            else if ((data_byte & LEAD4_MASK) == LEAD4_PAT)
            begin
                held_next = 2'd1;
                need_next = 2'd3;
                val_next  = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
            end
            else
            begin
                // Stray continuation or invalid lead
                new_desc.err_count = {1'b0, held_reg} + 3'd1;
            end
        end

        // Truncated text: flush whatever is still held
        if (text_end && (held_next != 2'd0))
        begin
            new_desc.err_count = new_desc.err_count + {1'b0, held_next};
            held_next          = 2'd0;
            need_next          = 2'd0;
            val_next           = '0;
        end

        if (!in_fire)
        begin
            held_next = held_reg;
            need_next = need_reg;
            val_next  = val_reg;
        end
    end

    // ------------------------------------------------------------------
    // Drain the descriptor one result per cycle, while the output stage is free
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = desc_valid_reg && out_free;
    // This emission is the last owed by the byte
    assign emit_last = (desc_reg.err_count == 3'd0)
                    || ((desc_reg.err_count == 3'd1) && !desc_reg.good);
    assign desc_done = emit && emit_last;
    assign in_ready  = !desc_valid_reg || desc_done;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        desc_next       = desc_reg;
        if (in_fire && ((new_desc.err_count != 3'd0) || new_desc.good))
        begin
            desc_valid_next = 1'b1;
            desc_next       = new_desc;
        end
        else if (desc_done)
        begin
            desc_valid_next = 1'b0;
        end
        else if (emit)
        begin
            // Only replacements can precede another result
            desc_next.err_count = desc_reg.err_count - 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        bad_next       = bad_reg;
        run_last_next  = run_last_reg;
        final_next     = final_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            bad_next       = desc_reg.err_count != 3'd0;
            cp_next        = (desc_reg.err_count != 3'd0) ? REPL_CHAR : desc_reg.cp;
            run_last_next  = emit_last;
            final_next     = emit_last && desc_reg.text_end;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 2'd0;
            need_reg       <= 2'd0;
            val_reg        <= '0;
            desc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            need_reg       <= need_next;
            val_reg        <= val_next;
            desc_valid_reg <= desc_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        cp_reg       <= cp_next;
        bad_reg      <= bad_next;
        run_last_reg <= run_last_next;
        final_reg    <= final_next;
    end

    assign out_valid    = out_valid_reg;
    assign code_point   = cp_reg;
    assign bad_sequence = bad_reg;
    assign run_last     = run_last_reg;
    assign final_result = final_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_needs_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == 2'd0) |-> (need_reg == 2'd0))
        else $error("continuation count set with no sequence held");

    a_seq_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != 2'd0) |-> (({1'b0, held_reg} + {1'b0, need_reg}) <= 3'd4))
        else $error("pending sequence longer than four bytes");

    a_desc_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> ((desc_reg.err_count != 3'd0) || desc_reg.good))
        else $error("descriptor held with no results owed");

    a_desc_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> (({1'b0, desc_reg.err_count} + {3'd0, desc_reg.good}) <= 4'd4))
        else $error("more than four results owed by one byte");

    a_final_has_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && final_reg) |-> run_last_reg)
        else $error("final result not marked as last of its byte");

endmodule
